### src/dfp_pkg.sv
// Shared types and constants for the download frame parser.
// No dependencies; used by dfp_front, dfp_back and download_frame_parser.
package dfp_pkg;

   localparam int HEADER_BYTES = 32;
   localparam int COUNT_BITS   = 20;
   localparam int HDR_IDX_BITS = $clog2(HEADER_BYTES);

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_D      = 8'h44;
   localparam logic [7:0] CHAR_F      = 8'h46;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SIX    = 8'h36;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_S      = 8'h53;

   // Slot codes carried in header byte 10
   localparam logic [7:0] SLOT_PROGRAM = 8'd0;
   localparam logic [7:0] SLOT_FONT    = 8'd1;
   localparam logic [7:0] SLOT_BITMAP  = 8'd2;
   localparam logic [7:0] SLOT_BOOT    = 8'd3;

   // Frame type letter codes
   localparam logic [1:0] TY_I = 2'd0;
   localparam logic [1:0] TY_B = 2'd1;
   localparam logic [1:0] TY_F = 2'd2;
   localparam logic [1:0] TY_S = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_HDR_BYTE = 3'd1;
   localparam logic [2:0] ST_HDR_OK   = 3'd2;
   localparam logic [2:0] ST_FMT_ERR  = 3'd3;
   localparam logic [2:0] ST_SIZE_ERR = 3'd4;
   localparam logic [2:0] ST_PAYLOAD  = 3'd5;
   localparam logic [2:0] ST_SUM_OK   = 3'd6;
   localparam logic [2:0] ST_SUM_BAD  = 3'd7;

   // One received byte with its character class
   typedef struct packed {
      logic [7:0] data;
      logic       is_dollar;
      logic       is_d;
      logic       is_f;
      logic       is_dot;
      logic       is_six;
      logic       type_ok;
      logic [1:0] type_code;
   } cls_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]            status;
      logic                  payload_valid;
      logic [7:0]            payload_byte;
      logic [18:0]           payload_offset;
      logic [1:0]            image_kind;
      logic [7:0]            bitmap_slot;
      logic [COUNT_BITS-1:0] frame_size;
      logic [15:0]           computed_sum;
   } rsp_type;

endpackage

### src/dfp_front.sv
// Front end: accepts received bytes, classifies them and queues them.
// Depends on dfp_pkg.
module dfp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [7:0]       rx_byte,
   output logic             cls_valid,
   output dfp_pkg::cls_type cls_item,
   input  logic             cls_pop
);

   dfp_pkg::cls_type cls_new;
   dfp_pkg::cls_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      cls_new           = '0;
      cls_new.data      = rx_byte;
      cls_new.is_dollar = (rx_byte == dfp_pkg::CHAR_DOLLAR);
      cls_new.is_d      = (rx_byte == dfp_pkg::CHAR_D);
      cls_new.is_f      = (rx_byte == dfp_pkg::CHAR_F);
      cls_new.is_dot    = (rx_byte == dfp_pkg::CHAR_DOT);
      cls_new.is_six    = (rx_byte == dfp_pkg::CHAR_SIX);
      cls_new.type_ok   = 1'b1;
      case (rx_byte)
         dfp_pkg::CHAR_I: cls_new.type_code = dfp_pkg::TY_I;
         dfp_pkg::CHAR_B: cls_new.type_code = dfp_pkg::TY_B;
         dfp_pkg::CHAR_F: cls_new.type_code = dfp_pkg::TY_F;
         dfp_pkg::CHAR_S: cls_new.type_code = dfp_pkg::TY_S;
         default: begin
            cls_new.type_code = dfp_pkg::TY_I;
            cls_new.type_ok   = 1'b0;
         end
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cls_valid = (count_ff != 2'd0);
   assign cls_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cls_pop && cls_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

### src/dfp_back.sv
// Back end: frame state machine, header check, payload sum and result queue.
// Depends on dfp_pkg.
module dfp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cls_valid,
   input  dfp_pkg::cls_type cls_item,
   output logic             cls_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output dfp_pkg::rsp_type rsp_item
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam int IB = dfp_pkg::HDR_IDX_BITS;
   localparam int CB = dfp_pkg::COUNT_BITS;

   localparam logic [IB-1:0] POS_D     = IB'(1);
   localparam logic [IB-1:0] POS_F     = IB'(2);
   localparam logic [IB-1:0] POS_TYPE  = IB'(3);
   localparam logic [IB-1:0] POS_SIX   = IB'(4);
   localparam logic [IB-1:0] POS_DOT   = IB'(6);
   localparam logic [IB-1:0] POS_KIND  = IB'(10);
   localparam logic [IB-1:0] POS_SLOT  = IB'(11);
   localparam logic [IB-1:0] POS_SIZE0 = IB'(15);
   localparam logic [IB-1:0] POS_SIZE1 = IB'(16);
   localparam logic [IB-1:0] POS_SIZE2 = IB'(17);
   localparam logic [IB-1:0] POS_SUM0  = IB'(20);
   localparam logic [IB-1:0] POS_SUM1  = IB'(21);
   localparam logic [IB-1:0] POS_LAST  = IB'(dfp_pkg::HEADER_BYTES - 1);

   localparam logic [24:0] SIZE_ADD  = 25'h20;
   localparam logic [24:0] UP_BOOT   = 25'h00FFE0;
   localparam logic [24:0] LO_BOOT   = 25'h008000;
   localparam logic [24:0] UP_BITMAP = 25'h080000;
   localparam logic [24:0] LO_BITMAP = 25'h010000;
   localparam logic [24:0] UP_FONT   = 25'h01FFF0;
   localparam logic [24:0] LO_FONT   = 25'h018000;
   localparam logic [24:0] UP_PROG   = 25'h03FFE0;
   localparam logic [24:0] LO_PROG   = 25'h018000;

   // Frame state
   logic [1:0]    phase_ff, phase_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] frame_len_ff, frame_len_in;
   logic [15:0]   exp_sum_ff, exp_sum_in;
   logic [15:0]   run_sum_ff, run_sum_in;
   logic [1:0]    kind_ff, kind_in;

   // Header fields captured on the fly (no reset: always written before use)
   logic       d_ok_ff, d_ok_in, f_ok_ff, f_ok_in, six_ok_ff, six_ok_in;
   logic       dot_ok_ff, dot_ok_in, type_ok_ff, type_ok_in;
   logic [1:0] type_ff, type_in;
   logic [7:0] kind_byte_ff, kind_byte_in, slot_ff, slot_in;
   logic [7:0] size0_ff, size0_in, size1_ff, size1_in, size2_ff, size2_in;
   logic [7:0] sum0_ff, sum0_in, sum1_ff, sum1_in;

   logic [IB-1:0]    idx;
   logic [24:0]      size;
   logic [24:0]      upper, lower;
   logic             fmt_bad, size_bad;
   logic [CB-1:0]    off_full;
   logic             take;
   dfp_pkg::rsp_type res;

   // Result queue
   dfp_pkg::rsp_type rq_mem_ff [2];
   logic       rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [1:0] rq_count_ff, rq_count_in;
   logic       rq_pop;

   assign take    = cls_valid && (rq_count_ff != 2'd2);
   assign cls_pop = take;
   assign idx     = count_ff[IB-1:0];

   // Header check over the captured fields
   always_comb begin
      size    = {1'b0, size2_ff, size1_ff, size0_ff} + SIZE_ADD;
      fmt_bad = !(d_ok_ff && f_ok_ff && type_ok_ff && dot_ok_ff);
      upper   = '0;
      lower   = '0;
      if (kind_byte_ff == dfp_pkg::SLOT_BOOT && type_ff == dfp_pkg::TY_B) begin
         upper = UP_BOOT;
         lower = LO_BOOT;
      end else if (kind_byte_ff == dfp_pkg::SLOT_BITMAP && type_ff == dfp_pkg::TY_S) begin
         upper = UP_BITMAP;
         lower = LO_BITMAP;
      end else if (kind_byte_ff == dfp_pkg::SLOT_FONT && type_ff == dfp_pkg::TY_F) begin
         upper = UP_FONT;
         lower = LO_FONT;
      end else if (kind_byte_ff == dfp_pkg::SLOT_PROGRAM && type_ff == dfp_pkg::TY_I &&
                   six_ok_ff) begin
         upper = UP_PROG;
         lower = LO_PROG;
      end
      size_bad = (size > upper) || (size < lower);
   end

   assign off_full = count_ff - CB'(dfp_pkg::HEADER_BYTES);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      frame_len_in = frame_len_ff;
      exp_sum_in   = exp_sum_ff;
      run_sum_in   = run_sum_ff;
      kind_in      = kind_ff;
      d_ok_in      = d_ok_ff;
      f_ok_in      = f_ok_ff;
      six_ok_in    = six_ok_ff;
      dot_ok_in    = dot_ok_ff;
      type_ok_in   = type_ok_ff;
      type_in      = type_ff;
      kind_byte_in = kind_byte_ff;
      slot_in      = slot_ff;
      size0_in     = size0_ff;
      size1_in     = size1_ff;
      size2_in     = size2_ff;
      sum0_in      = sum0_ff;
      sum1_in      = sum1_ff;
      res          = '0;
      res.status   = dfp_pkg::ST_IGNORED;

      case (phase_ff)
         PH_HEADER: begin
            case (idx)
               POS_D:     d_ok_in = cls_item.is_d;
               POS_F:     f_ok_in = cls_item.is_f;
               POS_TYPE: begin
                  type_ok_in = cls_item.type_ok;
                  type_in    = cls_item.type_code;
               end
               POS_SIX:   six_ok_in    = cls_item.is_six;
               POS_DOT:   dot_ok_in    = cls_item.is_dot;
               POS_KIND:  kind_byte_in = cls_item.data;
               POS_SLOT:  slot_in      = cls_item.data;
               POS_SIZE0: size0_in     = cls_item.data;
               POS_SIZE1: size1_in     = cls_item.data;
               POS_SIZE2: size2_in     = cls_item.data;
               POS_SUM0:  sum0_in      = cls_item.data;
               POS_SUM1:  sum1_in      = cls_item.data;
               default: ;
            endcase
            count_in   = count_ff + 1'b1;
            res.status = dfp_pkg::ST_HDR_BYTE;
            if (idx == POS_LAST) begin
               if (fmt_bad) begin
                  res.status = dfp_pkg::ST_FMT_ERR;
                  phase_in   = PH_IDLE;
               end else if (size_bad) begin
                  res.status = dfp_pkg::ST_SIZE_ERR;
                  phase_in   = PH_IDLE;
               end else begin
                  res.status      = dfp_pkg::ST_HDR_OK;
                  phase_in        = PH_PAYLOAD;
                  frame_len_in    = size[CB-1:0];
                  exp_sum_in      = {sum1_ff, sum0_ff};
                  kind_in         = kind_byte_ff[1:0];
                  run_sum_in      = '0;
                  res.image_kind  = kind_byte_ff[1:0];
                  res.bitmap_slot = slot_ff;
                  res.frame_size  = size[CB-1:0];
               end
            end
         end
         PH_PAYLOAD: begin
            run_sum_in         = run_sum_ff + {8'd0, cls_item.data};
            count_in           = count_ff + 1'b1;
            res.payload_valid  = 1'b1;
            res.payload_byte   = cls_item.data;
            res.payload_offset = off_full[18:0];
            res.image_kind     = kind_ff;
            res.bitmap_slot    = slot_ff;
            res.frame_size     = frame_len_ff;
            res.computed_sum   = run_sum_in;
            if (count_in >= frame_len_ff) begin
               res.status = (run_sum_in == exp_sum_ff) ? dfp_pkg::ST_SUM_OK
                                                        : dfp_pkg::ST_SUM_BAD;
               phase_in   = PH_IDLE;
            end else begin
               res.status = dfp_pkg::ST_PAYLOAD;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (cls_item.is_dollar) begin
               count_in   = CB'(1);
               phase_in   = PH_HEADER;
               res.status = dfp_pkg::ST_HDR_BYTE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         frame_len_ff <= '0;
         exp_sum_ff   <= '0;
         run_sum_ff   <= '0;
         kind_ff      <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         frame_len_ff <= frame_len_in;
         exp_sum_ff   <= exp_sum_in;
         run_sum_ff   <= run_sum_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         d_ok_ff      <= d_ok_in;
         f_ok_ff      <= f_ok_in;
         six_ok_ff    <= six_ok_in;
         dot_ok_ff    <= dot_ok_in;
         type_ok_ff   <= type_ok_in;
         type_ff      <= type_in;
         kind_byte_ff <= kind_byte_in;
         slot_ff      <= slot_in;
         size0_ff     <= size0_in;
         size1_ff     <= size1_in;
         size2_ff     <= size2_in;
         sum0_ff      <= sum0_in;
         sum1_ff      <= sum1_in;
      end
   end

   // Result queue, two entries
   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_item  = rq_mem_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      rq_wr_in    = take ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop ? ~rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + {1'b0, take} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rq_mem_ff[rq_wr_ff] <= res;
      end
   end

endmodule

### src/download_frame_parser.sv
// Top level of the download frame parser: byte classifier front end feeding
// the frame state machine back end. Depends on dfp_pkg, dfp_front, dfp_back.
//
// Usage:
//   Input channel: drive req_rx_byte and raise req_push; the byte is taken at
//   an edge where req_full is low. Each byte yields exactly one result
//   transaction (status plus frame and payload fields).
//   Result channel: while rsp_empty is low the oldest result sits on the rsp_
//   ports; raise rsp_pop to take it.
//   Path: a taken byte enters the two-entry classified queue; the back end
//   consumes it from there once the result queue has room, and its result
//   is written into the two-entry result queue.
//   Throughput: one byte per cycle, sustained, while rsp_pop takes each result
//   at once, with both queues running at a depth of one; the back end's header
//   check and payload add are combinational and never hold a byte back.
//   Stall: when rsp_pop stays low, the two-entry result queue fills, the back
//   end holds, the front queue fills and req_full rises; no transaction is
//   lost and all resume at full rate once rsp_pop returns.
//   Reset: synchronous, active high; drops all queued transactions and
//   returns the parser to waiting for the '$' that opens a frame.
module download_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [18:0] rsp_payload_offset,
   output logic [1:0]  rsp_image_kind,
   output logic [7:0]  rsp_bitmap_slot,
   output logic [19:0] rsp_frame_size,
   output logic [15:0] rsp_computed_sum
);

   logic             cls_valid;
   logic             cls_pop;
   dfp_pkg::cls_type cls_item;
   dfp_pkg::rsp_type rsp_item;

   // Accept and classify incoming bytes
   dfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .rx_byte   (req_rx_byte),
      .cls_valid (cls_valid),
      .cls_item  (cls_item),
      .cls_pop   (cls_pop)
   );

   // Advance the frame state and queue one result per byte
   dfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_item  (cls_item),
      .cls_pop   (cls_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_status         = rsp_item.status;
   assign rsp_payload_valid  = rsp_item.payload_valid;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_payload_offset = rsp_item.payload_offset;
   assign rsp_image_kind     = rsp_item.image_kind;
   assign rsp_bitmap_slot    = rsp_item.bitmap_slot;
   assign rsp_frame_size     = rsp_item.frame_size;
   assign rsp_computed_sum   = rsp_item.computed_sum;

`ifndef SYNTHESIS
   // Payload flag agrees with the payload status codes
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_payload_valid ==
         (rsp_status == dfp_pkg::ST_PAYLOAD || rsp_status == dfp_pkg::ST_SUM_OK ||
          rsp_status == dfp_pkg::ST_SUM_BAD)))
      else $error("payload flag and status disagree");

   // Non-payload results carry no sum and no offset
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_payload_valid) |->
         (rsp_computed_sum == 16'd0 && rsp_payload_offset == 19'd0))
      else $error("non-payload result carries payload data");

   // An accepted header always reports a size inside the widest bounds
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == dfp_pkg::ST_HDR_OK) |->
         (rsp_frame_size >= 20'h08000 && rsp_frame_size <= 20'h80000))
      else $error("accepted header with out-of-range size");
`endif

endmodule
